### rtl/aaus_pkg.sv
// Package for the Annex-B access unit splitter.
// Holds the result record, byte codes, NAL header masks and register map.
// No dependencies.
`default_nettype none

package aaus_pkg;

	localparam logic [7:0] ZERO_BYTE  = 8'h00;
	localparam logic [7:0] START_BYTE = 8'h01;

	localparam logic [4:0] H264_TYPE_MASK  = 5'h1F;
	localparam logic [4:0] H264_NAL_SLICE  = 5'd1;
	localparam logic [4:0] H264_NAL_IDR    = 5'd5;
	localparam logic [5:0] H265_TYPE_MASK  = 6'h3F;
	localparam logic [5:0] H265_VCL_MAX    = 6'd31;

	localparam logic [1:0] ZRUN_MAX = 2'd3;
	localparam logic [1:0] ZRUN_MIN_START = 2'd2;

	localparam logic REG_CODEC_MODE = 1'b0;
	localparam logic CODEC_H265 = 1'b1;

	typedef struct packed {
		logic [31:0] unit_offset;
		logic [31:0] unit_length;
		logic        unit_has_video;
		logic        last_unit;
	} unit_rec_t;

endpackage

`default_nettype wire

### rtl/annexb_access_unit_splitter.sv
// Annex-B access unit splitter: start code scan, NAL classification,
// unit open/close tracking and a four-entry result queue.
// Depends on aaus_pkg.
//
//   channel | handshake          | payload
//   --------+--------------------+----------------------------------------------
//   in      | in_valid/in_stall  | data_byte, last_byte
//   out     | out_valid/out_stall| unit_offset, unit_length, unit_has_video,
//           |                    | last_unit
//   cfg     | APB write/read     | codec_mode at byte address 0
//
// One byte per clock when not stalled. Stream state updates in the accepting
// cycle and closed units go to a four-entry queue; a byte can close up to two
// units, so input stalls while fewer than two queue slots are free. Reset clears
// stream state, codec_mode and the queue. Output stall only backs up the queue.
`default_nettype none

module annexb_access_unit_splitter
	import aaus_pkg::*;
#(
	parameter int OFFSET_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      unit_offset,
	output logic [31:0]      unit_length,
	output logic             unit_has_video,
	output logic             last_unit,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int OW = OFFSET_BITS;
	localparam logic [OW-1:0] OFF_MAX = {OW{1'b1}};

	typedef logic [OW-1:0] off_t;

	logic        codec_mode_q;
	off_t        byte_offset_q;
	logic [1:0]  zero_run_q;
	logic        header_pending_q;
	off_t        pending_nal_start_q;
	logic        unit_open_q;
	off_t        open_unit_start_q;
	logic        open_unit_video_q;

	unit_rec_t   fifo_q [4];
	logic [1:0]  rd_ptr_q;
	logic [1:0]  wr_ptr_q;
	logic [2:0]  count_q;

	logic        in_acc;
	logic        pop;
	logic        hdr_video;
	logic        start_det;
	off_t        back;
	off_t        nal_start_new;
	off_t        end_pos;

	logic        mid_emit;
	off_t        mid_len;
	logic        fin_emit;
	off_t        fin_len;
	logic        uo_a;
	off_t        us_a;
	logic        uv_a;
	logic        uo_b;
	off_t        us_b;
	logic        uv_b;

	logic [1:0]  zr_n;
	unit_rec_t   rec_mid;
	unit_rec_t   rec_fin;
	unit_rec_t   ent0;
	logic [1:0]  push_n;

	function automatic logic [31:0] to_out(input off_t v);
		logic [OW+31:0] ext;
		ext = {32'd0, v};
		return ext[31:0];
	endfunction

	// configuration port
	assign pready = 1'b1;

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == REG_CODEC_MODE) begin
			prdata = {31'd0, codec_mode_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codec_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_CODEC_MODE) begin
			codec_mode_q <= pwdata[0];
		end
	end

	assign in_stall = count_q > 3'd2;
	assign in_acc   = in_valid && !in_stall;
	assign out_valid = count_q != 3'd0;
	assign pop      = out_valid && !out_stall;

	always_comb begin
		if (codec_mode_q == CODEC_H265) begin
			hdr_video = ((data_byte[6:1] & H265_TYPE_MASK) <= H265_VCL_MAX);
		end else begin
			hdr_video = ((data_byte[4:0] & H264_TYPE_MASK) == H264_NAL_SLICE) ||
				((data_byte[4:0] & H264_TYPE_MASK) == H264_NAL_IDR);
		end
	end

	always_comb begin
		// NAL whose header is this byte
		uo_a     = unit_open_q;
		us_a     = open_unit_start_q;
		uv_a     = open_unit_video_q;
		mid_emit = 1'b0;
		mid_len  = (pending_nal_start_q >= open_unit_start_q) ?
			pending_nal_start_q - open_unit_start_q : '0;
		if (header_pending_q) begin
			if (!unit_open_q) begin
				uo_a = 1'b1;
				us_a = pending_nal_start_q;
				uv_a = hdr_video;
			end else if (hdr_video && open_unit_video_q) begin
				mid_emit = 1'b1;
				us_a     = pending_nal_start_q;
				uv_a     = 1'b1;
			end else begin
				uv_a = open_unit_video_q || hdr_video;
			end
		end

		// start code scan
		start_det = (data_byte == START_BYTE) && (zero_run_q >= ZRUN_MIN_START);
		back = (zero_run_q == ZRUN_MAX) ? off_t'(3) : off_t'(2);
		nal_start_new = (byte_offset_q >= back) ? byte_offset_q - back : '0;
		if (data_byte == ZERO_BYTE) begin
			zr_n = (zero_run_q == ZRUN_MAX) ? ZRUN_MAX : zero_run_q + 2'd1;
		end else begin
			zr_n = 2'd0;
		end

		// stream end: headerless NAL counts as non-video
		uo_b = uo_a;
		us_b = us_a;
		uv_b = uv_a;
		if (start_det && !uo_a) begin
			uo_b = 1'b1;
			us_b = nal_start_new;
			uv_b = 1'b0;
		end
		end_pos  = (byte_offset_q == OFF_MAX) ? OFF_MAX : byte_offset_q + off_t'(1);
		fin_len  = (end_pos >= us_b) ? end_pos - us_b : '0;
		fin_emit = last_byte && uo_b;

		rec_mid.unit_offset    = to_out(open_unit_start_q);
		rec_mid.unit_length    = to_out(mid_len);
		rec_mid.unit_has_video = 1'b1;
		rec_mid.last_unit      = 1'b0;
		rec_fin.unit_offset    = to_out(us_b);
		rec_fin.unit_length    = to_out(fin_len);
		rec_fin.unit_has_video = uv_b;
		rec_fin.last_unit      = 1'b1;

		ent0   = mid_emit ? rec_mid : rec_fin;
		push_n = {1'b0, mid_emit} + {1'b0, fin_emit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q       <= '0;
			zero_run_q          <= 2'd0;
			header_pending_q    <= 1'b0;
			pending_nal_start_q <= '0;
			unit_open_q         <= 1'b0;
			open_unit_start_q   <= '0;
			open_unit_video_q   <= 1'b0;
		end else if (in_acc) begin
			if (last_byte) begin
				byte_offset_q       <= '0;
				zero_run_q          <= 2'd0;
				header_pending_q    <= 1'b0;
				pending_nal_start_q <= '0;
				unit_open_q         <= 1'b0;
				open_unit_start_q   <= '0;
				open_unit_video_q   <= 1'b0;
			end else begin
				byte_offset_q     <= end_pos;
				zero_run_q        <= zr_n;
				header_pending_q  <= start_det;
				if (start_det) begin
					pending_nal_start_q <= nal_start_new;
				end
				unit_open_q       <= uo_a;
				open_unit_start_q <= us_a;
				open_unit_video_q <= uv_a;
			end
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (in_acc && push_n != 2'd0) begin
			fifo_q[wr_ptr_q] <= ent0;
			if (push_n == 2'd2) begin
				fifo_q[wr_ptr_q + 2'd1] <= rec_fin;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 2'd0;
			wr_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			if (in_acc) begin
				wr_ptr_q <= wr_ptr_q + push_n;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + (in_acc ? {1'b0, push_n} : 3'd0) - {2'd0, pop};
		end
	end

	assign unit_offset    = fifo_q[rd_ptr_q].unit_offset;
	assign unit_length    = fifo_q[rd_ptr_q].unit_length;
	assign unit_has_video = fifo_q[rd_ptr_q].unit_has_video;
	assign last_unit      = fifo_q[rd_ptr_q].last_unit;

endmodule

`default_nettype wire

### test/annexb_access_unit_splitter_tb.sv
// Testbench for annexb_access_unit_splitter: Annex-B byte streams in, access unit records out.
// A scoreboard class predicts every closed unit; streams are random-shaped with random idling.
// Depends on aaus_pkg and the annexb_access_unit_splitter RTL.
`default_nettype none

module annexb_access_unit_splitter_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import aaus_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 100;

	class unit_predictor;
		unit_rec_t expected_units[$];
		bit        mode_h265;
		bit [31:0] byte_pos;
		bit [1:0]  zeros;
		bit        hdr_wait;
		bit [31:0] nal_start;
		bit        au_open;
		bit [31:0] au_start;
		bit        au_video;
		int        errors;

		function new();
			mode_h265 = 1'b0;
			errors = 0;
			clear_stream();
		endfunction

		function void clear_stream();
			byte_pos = '0;
			zeros = '0;
			hdr_wait = 1'b0;
			nal_start = '0;
			au_open = 1'b0;
			au_start = '0;
			au_video = 1'b0;
		endfunction

		function void push_unit(bit [31:0] off, bit [31:0] len, bit vid, bit last);
			unit_rec_t r;
			r.unit_offset = off;
			r.unit_length = len;
			r.unit_has_video = vid;
			r.last_unit = last;
			expected_units.push_back(r);
		endfunction

		function void take_nal(bit [31:0] start, bit video);
			if (!au_open) begin
				au_open = 1'b1;
				au_start = start;
				au_video = 1'b0;
			end else if (video && au_video) begin
				push_unit(au_start, (start >= au_start) ? start - au_start : 32'd0, 1'b1, 1'b0);
				au_start = start;
				au_video = 1'b0;
			end
			au_video = au_video | video;
		endfunction

		// accepted input transaction
		function void note_byte(bit [7:0] b, bit last);
			bit [31:0] pos;
			bit [31:0] back;
			bit [32:0] stop;
			bit        video;
			pos = byte_pos;
			if (hdr_wait) begin
				hdr_wait = 1'b0;
				if (mode_h265)
					video = (b[6:1] & H265_TYPE_MASK) <= H265_VCL_MAX;
				else
					video = ((b[4:0] & H264_TYPE_MASK) == H264_NAL_SLICE) ||
						((b[4:0] & H264_TYPE_MASK) == H264_NAL_IDR);
				take_nal(nal_start, video);
			end
			if (b == ZERO_BYTE) begin
				if (zeros < ZRUN_MAX)
					zeros++;
			end else begin
				if (b == START_BYTE && zeros >= ZRUN_MIN_START) begin
					back = (zeros == ZRUN_MAX) ? 32'd3 : 32'd2;
					nal_start = (pos >= back) ? pos - back : 32'd0;
					hdr_wait = 1'b1;
				end
				zeros = '0;
			end
			if (last) begin
				if (hdr_wait) begin
					hdr_wait = 1'b0;
					take_nal(nal_start, 1'b0);
				end
				if (au_open) begin
					stop = {1'b0, pos} + 33'd1;
					if (stop > 33'hFFFF_FFFF)
						stop = 33'hFFFF_FFFF;
					push_unit(au_start, (stop >= {1'b0, au_start}) ? 32'(stop - au_start) : 32'd0,
						au_video, 1'b1);
				end
				clear_stream();
			end else if (pos != '1) begin
				byte_pos = pos + 32'd1;
			end
		endfunction

		// accepted output transaction
		function void check_unit(unit_rec_t got);
			unit_rec_t exp;
			if (expected_units.size() == 0) begin
				$display("%0t: unexpected unit offset %h length %h video %b last %b", $time,
					got.unit_offset, got.unit_length, got.unit_has_video, got.last_unit);
				errors++;
				return;
			end
			exp = expected_units.pop_front();
			if (got.unit_offset !== exp.unit_offset) begin
				$display("%0t: unit_offset expected %h actual %h", $time,
					exp.unit_offset, got.unit_offset);
				errors++;
			end
			if (got.unit_length !== exp.unit_length) begin
				$display("%0t: unit_length expected %h actual %h", $time,
					exp.unit_length, got.unit_length);
				errors++;
			end
			if (got.unit_has_video !== exp.unit_has_video) begin
				$display("%0t: unit_has_video expected %b actual %b", $time,
					exp.unit_has_video, got.unit_has_video);
				errors++;
			end
			if (got.last_unit !== exp.last_unit) begin
				$display("%0t: last_unit expected %b actual %b", $time,
					exp.last_unit, got.last_unit);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] unit_offset;
	logic [31:0] unit_length;
	logic        unit_has_video;
	logic        last_unit;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	unit_predictor sb = new();
	int cycles;
	int burst_left;
	bit steady;
	int phase_items;
	int stall_mode;
	int stall_left;

	annexb_access_unit_splitter i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.unit_offset(unit_offset),
		.unit_length(unit_length),
		.unit_has_video(unit_has_video),
		.last_unit(last_unit),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		unit_rec_t got;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_byte(data_byte, last_byte);
			if (out_valid && !out_stall) begin
				got.unit_offset = unit_offset;
				got.unit_length = unit_length;
				got.unit_has_video = unit_has_video;
				got.last_unit = last_unit;
				sb.check_unit(got);
			end
		end
	end

	// receiver stall pattern, switching style every so often
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(16, 96);
		end
		stall_left--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= 1'($urandom_range(0, 1));
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= stall_left[1];
		endcase
	end

	task automatic send_byte(input bit [7:0] b, input bit last);
		int gap;
		if (burst_left == 0) begin
			gap = steady ? 0 :
				(($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3));
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		phase_items++;
	endtask

	task automatic send_bytes(input bit [7:0] strm[$]);
		foreach (strm[i])
			send_byte(strm[i], i == strm.size() - 1);
	endtask

	// random stream: mostly well-formed NAL sequences, sometimes noise
	task automatic send_stream();
		bit [7:0] strm[$];
		int nals;
		int cut;
		bit [5:0] t265;
		bit [4:0] t264;
		if ($urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(3, 16)) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: strm.push_back(ZERO_BYTE);
					4, 5: strm.push_back(START_BYTE);
					default: strm.push_back(8'($urandom_range(0, 255)));
				endcase
			end
		end else begin
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 4)) strm.push_back(8'($urandom_range(0, 255)));
			nals = $urandom_range(1, 6);
			cut = $urandom_range(0, 4);
			for (int k = 0; k < nals; k++) begin
				repeat (($urandom_range(0, 3) == 0) ? $urandom_range(3, 5) : 2)
					strm.push_back(ZERO_BYTE);
				strm.push_back(START_BYTE);
				if (k == nals - 1 && cut == 0)
					break;
				if (sb.mode_h265) begin
					t265 = $urandom_range(0, 1) ?
						6'($urandom_range(0, 31)) : 6'($urandom_range(32, 63));
					strm.push_back({1'($urandom_range(0, 1)), t265, 1'($urandom_range(0, 1))});
				end else begin
					t264 = $urandom_range(0, 1) ?
						($urandom_range(0, 1) ? H264_NAL_SLICE : H264_NAL_IDR) :
						5'($urandom_range(0, 31));
					strm.push_back({3'($urandom_range(0, 7)), t264});
				end
				if (k == nals - 1 && cut == 1)
					break;
				repeat ($urandom_range(0, 6)) strm.push_back(8'($urandom_range(0, 255)));
			end
		end
		send_bytes(strm);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic read_reg(input logic [2:0] addr, output logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		value = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_codec(input bit h265);
		logic [31:0] rd;
		while (sb.expected_units.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		write_reg({REG_CODEC_MODE, 2'b00}, {31'd0, h265});
		sb.mode_h265 = h265;
		read_reg({REG_CODEC_MODE, 2'b00}, rd);
		if (rd !== {31'd0, h265}) begin
			$display("%0t: codec_mode readback expected %h actual %h", $time, {31'd0, h265}, rd);
			sb.errors++;
		end
	endtask

	initial begin
		bit [7:0] strm[$];
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cycles = 0;
		burst_left = 0;
		steady = 1'b1;
		stall_mode = 0;
		stall_left = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: 2/3/4-zero start codes, non-video then video, video closing a unit,
		// start code on the last byte, last byte with no unit, header on the last byte
		// with a mid-stream close in the same transaction
		set_codec(1'b0);
		strm = '{8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h00, 8'h01, 8'h65,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h41, 8'h00, 8'h00, 8'h01};
		send_bytes(strm);
		strm = '{8'hFF};
		send_bytes(strm);
		strm = '{8'h00, 8'h00, 8'h01, 8'h65, 8'h00, 8'h00, 8'h01, 8'h41};
		send_bytes(strm);
		in_valid <= 1'b0;

		for (int ph = 0; ph < 4; ph++) begin
			set_codec(ph[0] == 1'b0);
			steady = (ph == 2);
			phase_items = 0;
			while (phase_items < PHASE_ITEMS)
				send_stream();
			in_valid <= 1'b0;
		end

		while (sb.expected_units.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

### annexb_access_unit_splitter.f
rtl/aaus_pkg.sv
rtl/annexb_access_unit_splitter.sv
test/annexb_access_unit_splitter_tb.sv
